@@ rtl/lz77d_pkg.sv @@
// Package for the LZ77 variant decompressor: item codes, phases, token kinds.
// No dependencies.
package lz77d_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] WANT_BYTE = 2'd0;
	localparam logic [1:0] WANT_TICK = 2'd1;
	localparam logic [1:0] WANT_IDLE = 2'd2;

	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_EXACT   = 3'd1;
	localparam logic [2:0] ST_MISMT   = 3'd2;
	localparam logic [2:0] ST_BADOFS  = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_OPCODE  = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_LITERAL = 5'b01000,
		PH_RUN     = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		K_SHORT   = 3'd0,
		K_LONG    = 3'd1,
		K_LITERAL = 3'd2,
		K_FILL    = 3'd3,
		K_INCFILL = 3'd4
	} kind_t;

	// history write and read request from the token decoder
	typedef struct packed {
		logic        we;
		logic [15:0] waddr;
		logic [7:0]  wdata;
		logic        re;
		logic [15:0] raddr;
	} hist_req_t;

endpackage

@@ rtl/lz77_variant_decompressor.sv @@
// Top level of the LZ77 variant decompressor: token decoder, history RMW, APB.
// Depends on lz77d_pkg and lz77d_history.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | op, in_byte
//  out     | res_valid | res_stall | out_valid, out_byte, wants, status
//  cfg     | psel/penable/pwrite/pready | - | paddr, pwdata, prdata
//
// One item per cycle. Item is decoded in stage 1 (history read issued for a
// copy tick), the copy byte is resolved in stage 2 from the memory port or
// forwarded from the last two writes. Reset clears control state only; the
// history starts undefined (unwritten bytes read back as anything).
// res_stall holds stage 2; input stalls while stage 2 is full and stalled.
module lz77_variant_decompressor #(
	parameter int WINDOW_DEPTH = 16384,
	parameter int SIZE_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [7:0]           in_byte,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic [1:0]           wants,
	output logic [2:0]           status,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import lz77d_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int PW = AW + 1;
	localparam int RW = SIZE_BITS + 2;

	logic [SIZE_BITS-1:0] exp_size_q;
	assign pready = 1'b1;
	assign prdata = 32'(exp_size_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) exp_size_q <= '0;
		else if (psel && penable && pwrite && paddr == 2'd0) exp_size_q <= pwdata[SIZE_BITS-1:0];
	end

	phase_t          phase_q;
	kind_t           kind_q;
	logic [AW-1:0]   wp_q;
	logic [PW-1:0]   prod_q;
	logic signed [RW-1:0] rem_q;
	logic [7:0]      op_byte_q;
	logic [7:0]      hb_q [4];
	logic [2:0]      have_q, need_q;
	logic [16:0]     len_q;
	logic [15:0]     ofs_q;
	logic [7:0]      fill_q, step_q;

	// stage 2
	logic            v_s2, ov_s2, copy_s2;
	logic [7:0]      byte_s2, step_s2;
	logic [1:0]      wants_s2;
	logic [2:0]      st_s2;
	logic [AW-1:0]   src_s2;
	logic [7:0]      rdata;
	// last two writes for forwarding
	logic            w1v_q, w2v_q;
	logic [AW-1:0]   w1a_q, w2a_q;
	logic [7:0]      w1d_q, w2d_q;

	logic adv, acc;
	assign adv = !v_s2 || !res_stall;
	assign in_stall = !adv;
	assign acc = in_valid && adv;

	// history write from stage 2 (final byte known there)
	logic [7:0]    res_byte;
	logic [AW-1:0] dst_s2;
	logic          fw1, fw2;
	assign fw1 = w1v_q && w1a_q == src_s2;
	assign fw2 = w2v_q && w2a_q == src_s2;
	always_comb begin
		if (fw1) res_byte = w1d_q + step_s2;
		else if (fw2) res_byte = w2d_q + step_s2;
		else res_byte = rdata + step_s2;
		if (!copy_s2) res_byte = byte_s2;
	end

	logic hw;
	assign hw = v_s2 && ov_s2 && adv;
	logic [AW-1:0] src_c;
	lz77d_history #(.WINDOW_DEPTH(WINDOW_DEPTH), .AW(AW)) u_hist (
		.clk(clk), .we(hw), .waddr(dst_s2), .wdata(res_byte),
		.re(adv), .raddr(src_c), .rdata(rdata));

	// next-state logic
	phase_t n_phase;
	kind_t n_kind;
	logic [AW-1:0] n_wp;
	logic [PW-1:0] n_prod;
	logic signed [RW-1:0] n_rem;
	logic [2:0] n_have, n_need, nd;
	logic [16:0] n_len;
	logic [15:0] n_ofs;
	logic [7:0] n_fill, n_step, n_opb, e_byte;
	logic [7:0] h0, h1, h2, h3;
	logic emit, copy, hwr;
	logic [2:0] st;
	logic [15:0] x;

	assign src_c = wp_q - ofs_q[AW-1:0];

	always_comb begin
		n_phase = phase_q; n_kind = kind_q; n_wp = wp_q; n_prod = prod_q;
		n_rem = rem_q; n_have = have_q; n_need = need_q; n_len = len_q;
		n_ofs = ofs_q; n_fill = fill_q; n_step = step_q; n_opb = op_byte_q;
		emit = 1'b0; copy = 1'b0; e_byte = 8'd0; st = ST_RUN; hwr = 1'b0;
		h0 = hb_q[0]; h1 = hb_q[1]; h2 = hb_q[2]; h3 = hb_q[3]; nd = 3'd0; x = '0;
		if (op == OP_START) begin
			n_rem = RW'($signed({1'b0, exp_size_q}));
			n_wp = '0; n_prod = '0; n_len = '0; n_have = '0; n_need = '0;
			if (exp_size_q == '0) begin n_phase = PH_IDLE; st = ST_EXACT; end
			else n_phase = PH_OPCODE;
		end else if (op == OP_BYTE && phase_q == PH_OPCODE) begin
			n_opb = in_byte; n_have = '0;
			if (!in_byte[7]) nd = 3'd1;
			else if (in_byte[6]) nd = 3'd2;
			else begin
				case (in_byte[5:0])
					6'd1: nd = 3'd1;
					6'd2, 6'd3: nd = 3'd2;
					6'd4, 6'd5: nd = 3'd3;
					6'd6: nd = 3'd4;
					default: nd = 3'd0;
				endcase
			end
			n_need = nd;
			if (nd != 3'd0) n_phase = PH_HEADER;
		end else if (op == OP_BYTE && phase_q == PH_HEADER) begin
			hwr = 1'b1;
			case (have_q[1:0])
				2'd0: h0 = in_byte;
				2'd1: h1 = in_byte;
				2'd2: h2 = in_byte;
				default: h3 = in_byte;
			endcase
			n_have = have_q + 3'd1;
			if (op_byte_q[7:6] == 2'b11 && n_have == 3'd2 && in_byte[7]) n_need = 3'd3;
			if (n_have >= n_need) begin
				n_step = 8'd0;
				if (!op_byte_q[7]) begin
					x = {op_byte_q, h0};
					n_kind = K_SHORT;
					n_len = (x[3:0] == 4'd0) ? 17'h10 : 17'(x[3:0]);
					n_ofs = (x[14:4] == '0) ? 16'h800 : 16'(x[14:4]);
				end else if (op_byte_q[6]) begin
					n_kind = K_LONG;
					x = {op_byte_q, h0};
					n_ofs = (x[13:0] == '0) ? 16'h4000 : 16'(x[13:0]);
					n_len = (h1[6:0] == '0) ? 17'h80 : 17'(h1[6:0]);
					if (h1[7]) n_step = h2;
				end else begin
					case (op_byte_q[5:0])
						6'd1: begin n_kind = K_LITERAL; n_len = (h0 == 0) ? 17'h100 : 17'(h0); end
						6'd2: begin n_kind = K_LITERAL;
							n_len = ({h0, h1} == 0) ? 17'h10000 : 17'({h0, h1}); end
						6'd3: begin n_kind = K_FILL; n_fill = h0;
							n_len = (h1 == 0) ? 17'h100 : 17'(h1); end
						6'd4: begin n_kind = K_FILL; n_fill = h0;
							n_len = ({h1, h2} == 0) ? 17'h10000 : 17'({h1, h2}); end
						6'd5: begin n_kind = K_INCFILL; n_fill = h0; n_step = h1;
							n_len = (h2 == 0) ? 17'h100 : 17'(h2); end
						default: begin n_kind = K_INCFILL; n_fill = h0; n_step = h1;
							n_len = ({h2, h3} == 0) ? 17'h10000 : 17'({h2, h3}); end
					endcase
				end
				if ((n_kind == K_SHORT || n_kind == K_LONG)
						&& 17'(n_ofs) > 17'(prod_q)) begin
					n_phase = PH_IDLE; st = ST_BADOFS;
				end else n_phase = (n_kind == K_LITERAL) ? PH_LITERAL : PH_RUN;
			end
		end else if ((op == OP_BYTE && phase_q == PH_LITERAL) ||
				(op == OP_TICK && phase_q == PH_RUN)) begin
			emit = 1'b1;
			if (op == OP_BYTE) e_byte = in_byte;
			else if (kind_q == K_SHORT || kind_q == K_LONG) copy = 1'b1;
			else begin
				e_byte = fill_q;
				if (kind_q == K_INCFILL) n_fill = fill_q + step_q;
			end
			n_wp = wp_q + AW'(1);
			if (prod_q < PW'(WINDOW_DEPTH)) n_prod = prod_q + PW'(1);
			n_rem = rem_q - RW'(1);
			if (len_q != '0) n_len = len_q - 17'd1;
			if (n_len == '0) begin
				if (n_rem <= 0) begin
					n_phase = PH_IDLE; st = (n_rem == 0) ? ST_EXACT : ST_MISMT;
				end else n_phase = PH_OPCODE;
			end
		end else st = ST_IGNORED;
	end

	logic [1:0] n_wants;
	always_comb begin
		unique case (n_phase)
			PH_IDLE: n_wants = WANT_IDLE;
			PH_RUN: n_wants = WANT_TICK;
			default: n_wants = WANT_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; kind_q <= K_SHORT; wp_q <= '0; prod_q <= '0;
			rem_q <= '0; op_byte_q <= '0; have_q <= '0; need_q <= '0; len_q <= '0;
			ofs_q <= '0; fill_q <= '0; step_q <= '0; v_s2 <= 1'b0;
			w1v_q <= 1'b0; w2v_q <= 1'b0;
			for (int i = 0; i < 4; i++) hb_q[i] <= '0;
		end else begin
			if (acc) begin
				phase_q <= n_phase; kind_q <= n_kind; wp_q <= n_wp; prod_q <= n_prod;
				rem_q <= n_rem; op_byte_q <= n_opb; have_q <= n_have; need_q <= n_need;
				len_q <= n_len; ofs_q <= n_ofs; fill_q <= n_fill; step_q <= n_step;
				if (hwr) begin
					hb_q[0] <= h0; hb_q[1] <= h1; hb_q[2] <= h2; hb_q[3] <= h3;
				end
			end
			if (adv) v_s2 <= acc;
			if (adv) begin
				w1v_q <= hw; w2v_q <= w1v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ov_s2 <= emit; copy_s2 <= copy; byte_s2 <= e_byte; step_s2 <= step_q;
			wants_s2 <= n_wants; st_s2 <= st; src_s2 <= src_c; dst_s2 <= wp_q;
			w1a_q <= dst_s2; w1d_q <= res_byte; w2a_q <= w1a_q; w2d_q <= w1d_q;
		end
	end

	assign res_valid = v_s2;
	assign out_valid = ov_s2;
	assign out_byte = ov_s2 ? res_byte : 8'd0;
	assign wants = wants_s2;
	assign status = st_s2;
endmodule

@@ rtl/lz77d_history.sv @@
// History window memory with one write and one registered read port.
// The read register holds while re is low. No dependencies.
module lz77d_history #(
	parameter int WINDOW_DEPTH = 16384,
	parameter int AW = 14
) (
	input  logic       clk,
	input  logic       we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  logic [AW-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem [WINDOW_DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

@@ rtl/lz77d_checker.sv @@
// Port-level checker for the decompressor, bound to the top level.
// Depends on lz77d_pkg.
module lz77d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic       out_valid,
	input logic [7:0] out_byte,
	input logic [1:0] wants,
	input logic [2:0] status
);
	import lz77d_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(status))
		else $error("stalled result changed");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0)
		else $error("out_byte set without out_valid");
	a_ign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_IGNORED |-> !out_valid)
		else $error("ignored item produced a byte");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_EXACT || status == ST_MISMT || status == ST_BADOFS)
		|-> wants == WANT_IDLE)
		else $error("finished stream not idle");
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> in_stall)
		else $error("input taken while result stalled");
endmodule

bind lz77_variant_decompressor lz77d_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.res_valid(res_valid), .res_stall(res_stall), .out_valid(out_valid),
	.out_byte(out_byte), .wants(wants), .status(status));

@@ tb/tb.sv @@
// Self-checking testbench for lz77_variant_decompressor: random and directed token streams,
// checked item by item against a behavioral decoder kept in this file.
// Depends on lz77d_pkg and the decompressor RTL.
`timescale 1ns / 1ps

module tb;
	import lz77d_pkg::*;

	localparam logic [1:0] OP_BAD = 2'd3;
	localparam logic [1:0] REG_EXPECTED_SIZE = 2'd0;
	localparam int WIN = 16384;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data;
	} item_t;

	typedef struct {
		bit       ov;
		bit [7:0] ob;
		bit [1:0] w;
		bit [2:0] st;
	} res_t;

	logic clk, arst_n;
	logic in_valid, in_stall, res_valid, res_stall, out_valid;
	logic [1:0] op, wants, paddr;
	logic [7:0] in_byte, out_byte;
	logic [2:0] status;
	logic psel, penable, pwrite, pready;
	logic [31:0] pwdata, prdata;

	lz77_variant_decompressor dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// ---------------- decoder prediction ----------------
	bit [7:0]  hist [WIN];
	bit [13:0] wp;
	int        prod;
	longint    rem;
	phase_t    ph;
	kind_t     kind;
	bit [7:0]  hdr [4];
	bit [7:0]  opc;
	int        have, need, rlen, coff;
	bit [7:0]  fillv, stepv;
	bit [23:0] size_reg;

	function automatic bit [1:0] want_now();
		if (ph == PH_IDLE) return WANT_IDLE;
		if (ph == PH_RUN) return WANT_TICK;
		return WANT_BYTE;
	endfunction

	function automatic bit [2:0] close_token();
		if (rem <= 0) begin
			ph = PH_IDLE;
			return rem == 0 ? ST_EXACT : ST_MISMT;
		end
		ph = PH_OPCODE;
		return ST_RUN;
	endfunction

	function automatic void put_out(bit [7:0] v);
		hist[wp] = v;
		wp = wp + 1'b1;
		if (prod < WIN) prod++;
		rem--;
		if (rlen > 0) rlen--;
	endfunction

	function automatic int l8(bit [7:0] v);
		return v == 0 ? 'h100 : v;
	endfunction

	function automatic int l16(bit [7:0] hi, bit [7:0] lo);
		return {hi, lo} == 0 ? 'h10000 : {hi, lo};
	endfunction

	function automatic bit [2:0] setup_token();
		bit [15:0] x;
		x = {opc, hdr[0]};
		stepv = 0;
		if (!opc[7]) begin
			kind = K_SHORT;
			rlen = x[3:0] == 0 ? 16 : x[3:0];
			coff = x[14:4] == 0 ? 'h800 : x[14:4];
		end else if (opc[6]) begin
			kind = K_LONG;
			coff = x[13:0] == 0 ? 'h4000 : x[13:0];
			rlen = hdr[1][6:0] == 0 ? 'h80 : hdr[1][6:0];
			if (hdr[1][7]) stepv = hdr[2];
		end else begin
			case (opc[5:0])
				1: begin kind = K_LITERAL; rlen = l8(hdr[0]); end
				2: begin kind = K_LITERAL; rlen = l16(hdr[0], hdr[1]); end
				3: begin kind = K_FILL; fillv = hdr[0]; rlen = l8(hdr[1]); end
				4: begin kind = K_FILL; fillv = hdr[0]; rlen = l16(hdr[1], hdr[2]); end
				5: begin
					kind = K_INCFILL; fillv = hdr[0]; stepv = hdr[1]; rlen = l8(hdr[2]);
				end
				default: begin
					kind = K_INCFILL; fillv = hdr[0]; stepv = hdr[1];
					rlen = l16(hdr[2], hdr[3]);
				end
			endcase
		end
		if ((kind == K_SHORT || kind == K_LONG) && coff > prod) begin
			ph = PH_IDLE;
			return ST_BADOFS;
		end
		ph = (kind == K_LITERAL) ? PH_LITERAL : PH_RUN;
		return ST_RUN;
	endfunction

	function automatic res_t decode_item(bit [1:0] o, bit [7:0] b);
		res_t r;
		bit [7:0] v;
		bit [13:0] src;
		r = '{0, 0, 0, ST_RUN};
		if (o == OP_START) begin
			rem = size_reg;
			wp = 0; prod = 0; rlen = 0; have = 0; need = 0;
			if (rem <= 0) begin
				ph = PH_IDLE;
				r.st = ST_EXACT;
			end else ph = PH_OPCODE;
		end else if (o == OP_BYTE && ph == PH_OPCODE) begin
			opc = b;
			have = 0;
			if (!b[7]) need = 1;
			else if (b[6]) need = 2;
			else case (b[5:0])
				1: need = 1;
				2, 3: need = 2;
				4, 5: need = 3;
				6: need = 4;
				default: need = 0;
			endcase
			if (need > 0) ph = PH_HEADER;
		end else if (o == OP_BYTE && ph == PH_HEADER) begin
			if (have < 4) hdr[have] = b;
			have++;
			if (opc[7:6] == 2'b11 && have == 2 && b[7]) need = 3;
			if (have >= need) r.st = setup_token();
		end else if (o == OP_BYTE && ph == PH_LITERAL) begin
			put_out(b);
			if (rlen == 0) r.st = close_token();
			r.ov = 1; r.ob = b;
		end else if (o == OP_TICK && ph == PH_RUN) begin
			if (kind == K_SHORT || kind == K_LONG) begin
				src = wp - coff[13:0];
				v = hist[src] + stepv;
			end else begin
				v = fillv;
				if (kind == K_INCFILL) fillv = fillv + stepv;
			end
			put_out(v);
			if (rlen == 0) r.st = close_token();
			r.ov = 1; r.ob = v;
		end else r.st = ST_IGNORED;
		r.w = want_now();
		return r;
	endfunction

	// ---------------- driver / monitor ----------------
	item_t item_q[$];
	res_t  res_q[$];
	int    fails, n_items, n_bytes, n_results, n_streams;
	int    gap_max, gap_left, stall_left, hold_left;
	bit    in_hit, res_hit, hold_req, hold_seen;

	always @(posedge clk) begin
		in_hit <= in_valid && !in_stall;
		res_hit <= res_valid && !res_stall;
		if (arst_n && in_valid && !in_stall) begin
			res_q.push_back(decode_item(op, in_byte));
			n_items++;
		end
		if (arst_n && res_valid && !res_stall) begin
			res_t e;
			n_results++;
			if (res_q.size() == 0) begin
				$error("result with no item pending");
				fails++;
			end else begin
				e = res_q.pop_front();
				if (out_valid !== e.ov) begin
					$error("out_valid exp %0d got %0d", e.ov, out_valid); fails++;
				end
				if (out_byte !== e.ob) begin
					$error("out_byte exp %0h got %0h", e.ob, out_byte); fails++;
				end
				if (wants !== e.w) begin
					$error("wants exp %0d got %0d", e.w, wants); fails++;
				end
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); fails++;
				end
				if (out_valid === 1'b1) n_bytes++;
			end
		end
	end

	function automatic int draw_gap();
		if (gap_max == 0 || $urandom_range(1, 0)) return 0;
		return $urandom_range(gap_max, 0);
	endfunction

	always @(negedge clk) begin
		item_t it;
		bit nv;
		if (arst_n && (!in_valid || in_hit)) begin
			nv = 0;
			if (gap_left > 0) gap_left--;
			else if (item_q.size() > 0) begin
				it = item_q.pop_front();
				op <= it.op;
				in_byte <= it.data;
				nv = 1;
				gap_left = draw_gap();
			end
			in_valid <= nv;
		end
	end

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 400;
		end
		if (res_hit) stall_left = draw_gap();
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_stall <= 1;
		end else res_stall <= 0;
	end

	// ---------------- stream generation ----------------
	int     g_prod, g_gen;
	longint g_rem;
	bit     g_live;

	task automatic put(logic [1:0] o, logic [7:0] b);
		if ($urandom_range(99, 0) < 4) begin
			if ($urandom_range(1, 0)) item_q.push_back('{OP_BAD, 8'($urandom()) });
			else if (o == OP_BYTE) item_q.push_back('{OP_TICK, 8'($urandom())});
			else if (o == OP_TICK) item_q.push_back('{OP_BYTE, 8'($urandom())});
		end
		item_q.push_back('{o, b});
		g_gen++;
	endtask

	task automatic emitted(int len);
		g_prod = g_prod + len > WIN ? WIN : g_prod + len;
		g_rem -= len;
		if (g_rem <= 0) g_live = 0;
	endtask

	task automatic start_stream();
		put(OP_START, 8'($urandom()));
		g_rem = size_reg;
		g_prod = 0;
		g_live = size_reg != 0;
		n_streams++;
	endtask

	task automatic tok_copy(bit is_long, int off, int len, bit use_step, bit [7:0] stp);
		bit [15:0] x;
		if (!is_long) begin
			x = {1'b0, 11'(off), 4'(len)};
			put(OP_BYTE, x[15:8]);
			put(OP_BYTE, x[7:0]);
		end else begin
			x = {2'b11, 14'(off)};
			put(OP_BYTE, x[15:8]);
			put(OP_BYTE, x[7:0]);
			put(OP_BYTE, {use_step, 7'(len)});
			if (use_step) put(OP_BYTE, stp);
		end
		if (off > g_prod) begin
			g_live = 0;
			return;
		end
		repeat (len) put(OP_TICK, 8'($urandom()));
		emitted(len);
	endtask

	task automatic tok_lit(bit wide, int len);
		put(OP_BYTE, wide ? 8'h82 : 8'h81);
		if (wide) put(OP_BYTE, 8'(len >> 8));
		put(OP_BYTE, 8'(len));
		repeat (len) put(OP_BYTE, 8'($urandom()));
		emitted(len);
	endtask

	task automatic tok_fill(int n, int len);
		put(OP_BYTE, 8'h80 | 8'(n));
		put(OP_BYTE, 8'($urandom()));
		if (n >= 5) put(OP_BYTE, 8'($urandom()));
		if (n == 4 || n == 6) put(OP_BYTE, 8'(len >> 8));
		put(OP_BYTE, 8'(len));
		repeat (len) put(OP_TICK, 8'($urandom()));
		emitted(len);
	endtask

	task automatic rand_token();
		int k, lim, off;
		k = $urandom_range(9, 0);
		if (g_prod == 0 && k < 3) k = 3;
		case (k)
			0: begin
				lim = g_prod > 2048 ? 2048 : g_prod;
				off = $urandom_range(lim, 1);
				tok_copy(0, off, $urandom_range(16, 1), 0, 0);
			end
			1: begin
				lim = g_prod > 16383 ? 16383 : g_prod;
				off = $urandom_range(lim, 1);
				tok_copy(1, off, $urandom_range(20, 1), $urandom_range(1, 0),
					8'($urandom()));
			end
			2: begin
				if (g_prod < 2048) tok_copy(0, $urandom_range(2048, g_prod + 1), 3, 0, 0);
				else tok_copy(1, $urandom_range(16383, g_prod + 1), 3, 0, 0);
			end
			3, 4: tok_lit(k == 4, $urandom_range(12, 1));
			5, 6, 7, 8: tok_fill(k - 2, $urandom_range(12, 1));
			default: put(OP_BYTE, $urandom_range(1, 0) ? 8'h80 : 8'h80 | 8'($urandom_range(63, 7)));
		endcase
	endtask

	task automatic rand_stream(int max_tok);
		int t;
		start_stream();
		t = 0;
		while (g_live && t < max_tok) begin
			rand_token();
			t++;
		end
		if (!g_live && $urandom_range(2, 0) == 0)
			item_q.push_back('{$urandom_range(1, 0) ? OP_TICK : OP_BYTE, 8'($urandom())});
	endtask

	// ---------------- configuration ----------------
	task automatic apb_access(bit wr, bit [31:0] wd, output bit [31:0] rd);
		@(negedge clk);
		psel <= 1; pwrite <= wr; penable <= 0; paddr <= REG_EXPECTED_SIZE; pwdata <= wd;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_size(bit [23:0] v);
		bit [31:0] rd;
		apb_access(1, v, rd);
		size_reg = v;
		apb_access(0, 0, rd);
		if (rd[23:0] !== v) begin
			$error("expected_size readback exp %0h got %0h", v, rd[23:0]);
			fails++;
		end
	endtask

	task automatic drain();
		while (item_q.size() > 0 || in_valid || res_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		int sz;
		clk = 0;
		arst_n = 0;
		in_valid = 0; op = OP_START; in_byte = 0; res_stall = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		ph = PH_IDLE; kind = K_SHORT;
		gap_max = 15;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty stream, idle noise, then every token kind
		set_size(0);
		start_stream();
		item_q.push_back('{OP_BYTE, 8'hff});
		item_q.push_back('{OP_TICK, 8'h00});
		item_q.push_back('{OP_BAD, 8'h00});
		drain();
		set_size(24);
		start_stream();
		tok_lit(0, 3);
		tok_copy(0, 2, 2, 0, 0);
		tok_copy(1, 5, 2, 1, 8'hff);
		put(OP_BYTE, 8'hbf);
		tok_fill(3, 2);
		tok_fill(5, 2);
		tok_lit(1, 1);
		tok_fill(4, 1);
		tok_fill(6, 10);
		start_stream();
		tok_copy(0, 4, 1, 0, 0);
		drain();

		// long holdoff on the result side
		set_size(60);
		hold_req = 1;
		start_stream();
		tok_lit(0, 30);
		tok_fill(3, 30);
		drain();

		while (g_gen < 160) begin
			case ($urandom_range(5, 0))
				0: sz = 0;
				1: sz = 1;
				2: sz = 24'hffffff;
				default: sz = $urandom_range(80, 2);
			endcase
			gap_max = $urandom_range(3, 0) == 0 ? 0 : 15;
			set_size(24'(sz));
			repeat ($urandom_range(4, 2)) rand_stream(12);
			drain();
		end

		// extremes: 256 literal with overrun, maximum long and short offsets
		gap_max = 0;
		set_size(300);
		start_stream();
		tok_lit(0, 'h100);
		tok_fill(3, 60);
		start_stream();
		tok_lit(0, 5);
		tok_copy(1, 'h4000, 'h80, 1, 8'h01);
		start_stream();
		tok_lit(0, 3);
		tok_copy(0, 'h800, 16, 0, 0);
		drain();
		gap_max = 15;
		set_size(24'hffffff);
		rand_stream(4);
		drain();

		$display("accepted %0d items in %0d streams; %0d results, %0d output bytes",
			n_items, n_streams, n_results, n_bytes);
		if (fails == 0) $display("lz77_variant_decompressor test passed");
		else $display("lz77_variant_decompressor test failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("lz77_variant_decompressor test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lz77d_pkg.sv
rtl/lz77d_history.sv
rtl/lz77_variant_decompressor.sv
rtl/lz77d_checker.sv
tb/tb.sv
